// ===== src/mi3_pkg.sv =====
// shared constants for the 3x3 fixed-point matrix inverse
package mi3_pkg;

    // entries in one matrix
    localparam int NUM_ENTRIES  = 9;
    // register stages in the cofactor and determinant front end
    localparam int FRONT_STAGES = 5;

endpackage

// ===== src/mi3_front.sv =====
// cofactor and determinant front end, five register stages
module mi3_front
    import mi3_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic                                        i_clk,
    input  logic [FRONT_STAGES-1:0]                     i_adv,
    input  logic [NUM_ENTRIES-1:0][DATA_WIDTH-1:0]      i_m,
    output logic [NUM_ENTRIES-1:0][2*DATA_WIDTH:0]      o_cof,
    output logic [3*DATA_WIDTH+1:0]                     o_det_abs,
    output logic                                        o_det_neg,
    output logic                                        o_det_zero
);

    localparam int PW  = 2 * DATA_WIDTH;
    localparam int CW  = 2 * DATA_WIDTH + 1;
    localparam int PPW = 2 * DATA_WIDTH + 1;
    localparam int DW  = 3 * DATA_WIDTH + 2;

    logic signed [PW-1:0]         r_p   [18];
    logic signed [DATA_WIDTH-1:0] r_a1  [3];
    logic signed [DATA_WIDTH-1:0] r_a2  [3];
    logic signed [CW-1:0]         r_c1  [NUM_ENTRIES];
    logic signed [CW-1:0]         r_c2  [NUM_ENTRIES];
    logic signed [CW-1:0]         r_c3  [NUM_ENTRIES];
    logic signed [CW-1:0]         r_c4  [NUM_ENTRIES];
    logic signed [PPW-1:0]        r_pl  [3];
    logic signed [PPW-1:0]        r_ph  [3];
    logic signed [DW-1:0]         r_det;
    logic [DW-1:0]                r_det_abs;
    logic                         r_det_neg;
    logic                         r_det_zero;

    logic signed [DATA_WIDTH-1:0] w_a [NUM_ENTRIES];
    logic signed [DW-1:0]         n_det;

    always_comb begin
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            w_a[i] = $signed(i_m[i]);
        end
    end

    // stage 0: the eighteen 2x2 minor products
    always_ff @(posedge i_clk) begin
        if (i_adv[0]) begin
            r_p[0]  <= PW'(w_a[4] * w_a[8]);
            r_p[1]  <= PW'(w_a[5] * w_a[7]);
            r_p[2]  <= PW'(w_a[2] * w_a[7]);
            r_p[3]  <= PW'(w_a[1] * w_a[8]);
            r_p[4]  <= PW'(w_a[1] * w_a[5]);
            r_p[5]  <= PW'(w_a[4] * w_a[2]);
            r_p[6]  <= PW'(w_a[5] * w_a[6]);
            r_p[7]  <= PW'(w_a[3] * w_a[8]);
            r_p[8]  <= PW'(w_a[0] * w_a[8]);
            r_p[9]  <= PW'(w_a[6] * w_a[2]);
            r_p[10] <= PW'(w_a[2] * w_a[3]);
            r_p[11] <= PW'(w_a[0] * w_a[5]);
            r_p[12] <= PW'(w_a[3] * w_a[7]);
            r_p[13] <= PW'(w_a[4] * w_a[6]);
            r_p[14] <= PW'(w_a[1] * w_a[6]);
            r_p[15] <= PW'(w_a[0] * w_a[7]);
            r_p[16] <= PW'(w_a[0] * w_a[4]);
            r_p[17] <= PW'(w_a[1] * w_a[3]);
            for (int i = 0; i < 3; i++) begin
                r_a1[i] <= w_a[i];
            end
        end
    end

    // stage 1: cofactors as differences of minor products
    always_ff @(posedge i_clk) begin
        if (i_adv[1]) begin
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                r_c1[i] <= {r_p[2*i][PW-1], r_p[2*i]}
                         - {r_p[2*i+1][PW-1], r_p[2*i+1]};
            end
            for (int i = 0; i < 3; i++) begin
                r_a2[i] <= r_a1[i];
            end
        end
    end

    // stage 2: first row times first column cofactors, split in two partial products
    always_ff @(posedge i_clk) begin
        if (i_adv[2]) begin
            for (int i = 0; i < 3; i++) begin
                r_pl[i] <= PPW'(r_a2[i] * $signed({1'b0, r_c1[3*i][DATA_WIDTH-1:0]}));
                r_ph[i] <= PPW'(r_a2[i] * $signed(r_c1[3*i][CW-1:DATA_WIDTH]));
            end
            r_c2 <= r_c1;
        end
    end

    // determinant sum of the partial products
    always_comb begin
        n_det = '0;
        for (int i = 0; i < 3; i++) begin
            n_det = n_det
                  + ($signed({{(DW-PPW){r_ph[i][PPW-1]}}, r_ph[i]}) <<< DATA_WIDTH)
                  + $signed({{(DW-PPW){r_pl[i][PPW-1]}}, r_pl[i]});
        end
    end

    // stage 3: determinant
    always_ff @(posedge i_clk) begin
        if (i_adv[3]) begin
            r_det <= n_det;
            r_c3  <= r_c2;
        end
    end

    // stage 4: determinant magnitude, sign and zero test
    always_ff @(posedge i_clk) begin
        if (i_adv[4]) begin
            r_det_abs  <= r_det[DW-1] ? DW'(-r_det) : DW'(r_det);
            r_det_neg  <= r_det[DW-1];
            r_det_zero <= (r_det == '0);
            r_c4       <= r_c3;
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            o_cof[i] = r_c4[i];
        end
    end

    assign o_det_abs  = r_det_abs;
    assign o_det_neg  = r_det_neg;
    assign o_det_zero = r_det_zero;

endmodule

// ===== src/mi3_div_lane.sv =====
// one divider lane: restoring division of a scaled cofactor by the determinant
module mi3_div_lane #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                    i_clk,
    input  logic [DATA_WIDTH:0]     i_adv,
    input  logic [2*DATA_WIDTH:0]   i_cof,
    input  logic [3*DATA_WIDTH+1:0] i_det_abs,
    input  logic                    i_det_neg,
    input  logic                    i_det_zero,
    output logic [DATA_WIDTH-1:0]   o_q,
    output logic                    o_neg,
    output logic                    o_ovf,
    output logic                    o_zero
);

    localparam int CW = 2 * DATA_WIDTH + 1;
    localparam int RW = 3 * DATA_WIDTH + 2;
    localparam int NW = CW + 2 * FRAC_BITS;
    localparam int HW = NW - DATA_WIDTH;
    localparam int XW = HW + RW;
    localparam int D  = DATA_WIDTH;

    logic [RW-1:0] r_rem  [D+1];
    logic [RW-1:0] r_den  [D+1];
    logic [D-1:0]  r_lo   [D+1];
    logic [D-1:0]  r_q    [D+1];
    logic          r_neg  [D+1];
    logic          r_ovf  [D+1];
    logic          r_zero [D+1];

    logic [CW-1:0] w_mag;
    logic [NW-1:0] w_num;
    logic [XW-1:0] w_hi_x;
    logic [XW-1:0] w_den_x;

    // numerator magnitude scaled by the fraction bits twice
    always_comb begin
        w_mag   = i_cof[CW-1] ? CW'(-i_cof) : i_cof;
        w_num   = {w_mag, {(2*FRAC_BITS){1'b0}}};
        w_hi_x  = XW'(w_num[NW-1:D]);
        w_den_x = XW'(i_det_abs);
    end

    // setup: the high numerator part is the remainder once the upper quotient bits are zero
    always_ff @(posedge i_clk) begin
        if (i_adv[0]) begin
            r_rem[0]  <= w_hi_x[RW-1:0];
            r_den[0]  <= i_det_abs;
            r_lo[0]   <= w_num[D-1:0];
            r_q[0]    <= '0;
            r_neg[0]  <= i_cof[CW-1] ^ i_det_neg;
            r_ovf[0]  <= (w_hi_x >= w_den_x);
            r_zero[0] <= i_det_zero;
        end
    end

    // one quotient bit per stage
    for (genvar k = 1; k <= D; k++) begin : g_step
        logic [RW:0] w_trial;
        logic [RW:0] w_diff;
        logic        w_take;

        always_comb begin
            w_trial = {r_rem[k-1], r_lo[k-1][D-1]};
            w_diff  = w_trial - {1'b0, r_den[k-1]};
            w_take  = (w_trial >= {1'b0, r_den[k-1]});
        end

        always_ff @(posedge i_clk) begin
            if (i_adv[k]) begin
                r_rem[k]  <= w_take ? w_diff[RW-1:0] : w_trial[RW-1:0];
                r_den[k]  <= r_den[k-1];
                r_lo[k]   <= {r_lo[k-1][D-2:0], 1'b0};
                r_q[k]    <= {r_q[k-1][D-2:0], w_take};
                r_neg[k]  <= r_neg[k-1];
                r_ovf[k]  <= r_ovf[k-1];
                r_zero[k] <= r_zero[k-1];
            end
        end
    end

    assign o_q    = r_q[D];
    assign o_neg  = r_neg[D];
    assign o_ovf  = r_ovf[D];
    assign o_zero = r_zero[D];

endmodule

// ===== src/matrix_inverse_3x3_top.sv =====
// 3x3 fixed-point matrix inverse through the adjugate, nine divider lanes
// pipeline: front-end stages, divider setup and quotient stages, then the output register
// throughput: one matrix per cycle unless stalled; one quotient bit per divider stage
// a stalled output fills the pipeline bubbles before input ready drops
// reset (synchronous, active low) clears all stage valid bits; data registers are not reset
module matrix_inverse_3x3_top
    import mi3_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [DATA_WIDTH-1:0] i_m11,
    input  logic signed [DATA_WIDTH-1:0] i_m12,
    input  logic signed [DATA_WIDTH-1:0] i_m13,
    input  logic signed [DATA_WIDTH-1:0] i_m21,
    input  logic signed [DATA_WIDTH-1:0] i_m22,
    input  logic signed [DATA_WIDTH-1:0] i_m23,
    input  logic signed [DATA_WIDTH-1:0] i_m31,
    input  logic signed [DATA_WIDTH-1:0] i_m32,
    input  logic signed [DATA_WIDTH-1:0] i_m33,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [DATA_WIDTH-1:0] o_r11,
    output logic signed [DATA_WIDTH-1:0] o_r12,
    output logic signed [DATA_WIDTH-1:0] o_r13,
    output logic signed [DATA_WIDTH-1:0] o_r21,
    output logic signed [DATA_WIDTH-1:0] o_r22,
    output logic signed [DATA_WIDTH-1:0] o_r23,
    output logic signed [DATA_WIDTH-1:0] o_r31,
    output logic signed [DATA_WIDTH-1:0] o_r32,
    output logic signed [DATA_WIDTH-1:0] o_r33,
    output logic                         o_singular
);

    localparam int D      = DATA_WIDTH;
    localparam int NSTAGE = FRONT_STAGES + D + 2;
    localparam int OUT_ST = NSTAGE - 1;

    logic [NSTAGE-1:0] r_vld;
    logic [NSTAGE:0]   w_adv;

    logic [NUM_ENTRIES-1:0][D-1:0] w_m;
    logic [NUM_ENTRIES-1:0][2*D:0] w_cof;
    logic [3*D+1:0]                w_det_abs;
    logic                          w_det_neg;
    logic                          w_det_zero;

    logic [D-1:0] w_q    [NUM_ENTRIES];
    logic         w_neg  [NUM_ENTRIES];
    logic         w_ovf  [NUM_ENTRIES];
    logic         w_zero [NUM_ENTRIES];

    logic [D-1:0] n_out  [NUM_ENTRIES];
    logic [D-1:0] r_out  [NUM_ENTRIES];
    logic         r_sing;

    // a stage moves when it is empty or the stage after it moves
    always_comb begin
        w_adv[NSTAGE] = i_ready;
        for (int k = NSTAGE - 1; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    assign o_ready = w_adv[0];
    assign o_valid = r_vld[OUT_ST];

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NSTAGE; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign w_m = {i_m33, i_m32, i_m31, i_m23, i_m22, i_m21, i_m13, i_m12, i_m11};

    mi3_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_adv      (w_adv[FRONT_STAGES-1:0]),
        .i_m        (w_m),
        .o_cof      (w_cof),
        .o_det_abs  (w_det_abs),
        .o_det_neg  (w_det_neg),
        .o_det_zero (w_det_zero)
    );

    // nine divider lanes, one per adjugate entry
    for (genvar i = 0; i < NUM_ENTRIES; i++) begin : g_lane
        mi3_div_lane #(
            .DATA_WIDTH (DATA_WIDTH),
            .FRAC_BITS  (FRAC_BITS)
        ) u_lane (
            .i_clk      (i_clk),
            .i_adv      (w_adv[FRONT_STAGES+D:FRONT_STAGES]),
            .i_cof      (w_cof[i]),
            .i_det_abs  (w_det_abs),
            .i_det_neg  (w_det_neg),
            .i_det_zero (w_det_zero),
            .o_q        (w_q[i]),
            .o_neg      (w_neg[i]),
            .o_ovf      (w_ovf[i]),
            .o_zero     (w_zero[i])
        );
    end

    // merge: saturate, apply sign, zero on a singular matrix
    always_comb begin
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            logic [D-1:0] lim;
            logic [D-1:0] mag;
            lim = {1'b1, {(D-1){1'b0}}} - {{(D-1){1'b0}}, !w_neg[i]};
            mag = (w_ovf[i] || (w_q[i] > lim)) ? lim : w_q[i];
            if (w_zero[0]) begin
                n_out[i] = '0;
            end else begin
                n_out[i] = w_neg[i] ? D'(-mag) : mag;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (w_adv[OUT_ST]) begin
            r_out  <= n_out;
            r_sing <= w_zero[0];
        end
    end

    assign o_r11      = r_out[0];
    assign o_r12      = r_out[1];
    assign o_r13      = r_out[2];
    assign o_r21      = r_out[3];
    assign o_r22      = r_out[4];
    assign o_r23      = r_out[5];
    assign o_r31      = r_out[6];
    assign o_r32      = r_out[7];
    assign o_r33      = r_out[8];
    assign o_singular = r_sing;

`ifndef SYNTHESIS
    // a singular result carries all-zero entries
    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_singular) |-> (o_r11 == '0 && o_r22 == '0 && o_r33 == '0
            && o_r12 == '0 && o_r13 == '0 && o_r21 == '0 && o_r23 == '0
            && o_r31 == '0 && o_r32 == '0))
        else $error("singular result with nonzero entries");

    // an accepted request lands in the first stage
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_vld[0])
        else $error("accepted request lost at pipeline entry");

    // an empty output stage never blocks the input
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[OUT_ST] |-> o_ready)
        else $error("input stalled with empty output stage");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
// self-checking testbench for the 3x3 fixed-point matrix inverse
`timescale 1ns / 100ps

module testbench;
    import mi3_pkg::*;

    localparam int DW        = 32;
    localparam int FB        = 16;
    localparam int LATENCY   = DW + 6;
    localparam int STALL_MAX = 4000;
    localparam logic [DW-1:0] ONE = 32'h0001_0000;

    typedef logic [NUM_ENTRIES-1:0][DW-1:0] t_mat;
    typedef struct packed {
        logic [NUM_ENTRIES-1:0][DW-1:0] r;
        logic                           singular;
    } t_inverse;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    logic o_valid;
    logic i_ready;
    logic signed [DW-1:0] i_m [NUM_ENTRIES];
    logic signed [DW-1:0] o_r [NUM_ENTRIES];
    logic o_singular;

    t_inverse inv_expected_q[$];
    int       n_fail;
    int       n_sent;
    int       n_checked;
    int       n_singular_seen;
    int       n_sat_seen;
    int       send_idle_pct;
    int       recv_idle_pct;
    int       recv_hold_cycles;
    int       quiet_cycles;

    matrix_inverse_3x3_top #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_m11      (i_m[0]),
        .i_m12      (i_m[1]),
        .i_m13      (i_m[2]),
        .i_m21      (i_m[3]),
        .i_m22      (i_m[4]),
        .i_m23      (i_m[5]),
        .i_m31      (i_m[6]),
        .i_m32      (i_m[7]),
        .i_m33      (i_m[8]),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_r11      (o_r[0]),
        .o_r12      (o_r[1]),
        .o_r13      (o_r[2]),
        .o_r21      (o_r[3]),
        .o_r22      (o_r[4]),
        .o_r23      (o_r[5]),
        .o_r31      (o_r[6]),
        .o_r32      (o_r[7]),
        .o_r33      (o_r[8]),
        .o_singular (o_singular)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // exact adjugate inverse: cofactor * 2^(2F) / det, truncated, saturated
    function automatic t_inverse invert_matrix(t_mat m);
        logic signed [127:0] a [NUM_ENTRIES];
        logic signed [127:0] cof [NUM_ENTRIES];
        logic signed [127:0] det;
        logic [191:0]        num;
        logic [191:0]        den;
        logic [191:0]        quo;
        logic [191:0]        lim;
        logic                neg;
        t_inverse            res;
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            a[i] = $signed(m[i]);
        end
        cof[0] = a[4] * a[8] - a[5] * a[7];
        cof[1] = a[2] * a[7] - a[1] * a[8];
        cof[2] = a[1] * a[5] - a[4] * a[2];
        cof[3] = a[5] * a[6] - a[3] * a[8];
        cof[4] = a[0] * a[8] - a[6] * a[2];
        cof[5] = a[2] * a[3] - a[0] * a[5];
        cof[6] = a[3] * a[7] - a[4] * a[6];
        cof[7] = a[1] * a[6] - a[0] * a[7];
        cof[8] = a[0] * a[4] - a[1] * a[3];
        det = a[0] * cof[0] + a[1] * cof[3] + a[2] * cof[6];
        res = '0;
        if (det == 0) begin
            res.singular = 1'b1;
            return res;
        end
        den = (det < 0) ? 192'(-det) : 192'(det);
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            neg = (cof[i] < 0) != (det < 0);
            num = (cof[i] < 0) ? 192'(-cof[i]) : 192'(cof[i]);
            num = num << (2 * FB);
            quo = num / den;
            lim = neg ? (192'(1) << (DW - 1)) : ((192'(1) << (DW - 1)) - 1);
            if (quo > lim) quo = lim;
            if (neg) quo = -quo;
            res.r[i] = quo[DW-1:0];
        end
        return res;
    endfunction

    // one request: optional idle gap, then hold valid until accepted
    task automatic send_matrix(t_mat m);
        @(negedge i_clk);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        for (int i = 0; i < NUM_ENTRIES; i++) i_m[i] = m[i];
        do @(posedge i_clk); while (!o_ready);
        inv_expected_q.push_back(invert_matrix(m));
        n_sent++;
    endtask

    task automatic drop_valid();
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (inv_expected_q.size() != 0) @(posedge i_clk);
    endtask

    // entry generators: full range, small or medium magnitude, or an extreme
    function automatic logic [DW-1:0] rand_entry();
        case ($urandom_range(9))
            0, 1, 2: return $urandom;
            3:       return 32'($signed($urandom_range(255)) - 128);
            4:       begin
                case ($urandom_range(5))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return 32'hffff_ffff;
                    3: return 32'h0000_0001;
                    4: return ONE;
                    default: return '0;
                endcase
            end
            default: return 32'($signed($urandom_range(1 << 19)) - (1 << 18));
        endcase
    endfunction

    function automatic t_mat rand_matrix();
        t_mat m;
        int   r;
        for (int i = 0; i < NUM_ENTRIES; i++) m[i] = rand_entry();
        r = $urandom_range(19);
        // rank-deficient shapes: repeated row, zero column, scaled row
        if (r == 0) begin
            for (int c = 0; c < 3; c++) m[6 + c] = m[c];
        end else if (r == 1) begin
            for (int k = 0; k < 3; k++) m[3 * k + 1] = '0;
        end else if (r == 2) begin
            for (int c = 0; c < 3; c++) m[3 + c] = 32'($signed($urandom_range(511)) - 256);
            for (int c = 0; c < 3; c++) m[c] = m[3 + c] <<< 2;
        end
        return m;
    endfunction

    function automatic t_mat diag_matrix(logic [DW-1:0] d0, logic [DW-1:0] d1,
                                         logic [DW-1:0] d2);
        t_mat m;
        m    = '0;
        m[0] = d0;
        m[4] = d1;
        m[8] = d2;
        return m;
    endfunction

    // receiver: random stalls plus a counted long hold-off
    always @(negedge i_clk) begin
        if (recv_hold_cycles > 0) begin
            i_ready = 1'b0;
            recv_hold_cycles--;
        end else begin
            i_ready = !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_inverse exp_inv;
        if (i_rst_n && o_valid && i_ready) begin
            if (inv_expected_q.size() == 0) begin
                $error("result with no request outstanding");
                n_fail++;
            end else begin
                exp_inv = inv_expected_q.pop_front();
                n_checked++;
                if (exp_inv.singular) n_singular_seen++;
                for (int i = 0; i < NUM_ENTRIES; i++) begin
                    if (o_r[i] != exp_inv.r[i]) begin
                        $error("r%0d%0d expected %h actual %h", i / 3 + 1, i % 3 + 1,
                               exp_inv.r[i], o_r[i]);
                        n_fail++;
                    end
                    if (exp_inv.r[i] == 32'h7fff_ffff || exp_inv.r[i] == 32'h8000_0000)
                        n_sat_seen++;
                end
                if (o_singular != exp_inv.singular) begin
                    $error("singular expected %b actual %b", exp_inv.singular, o_singular);
                    n_fail++;
                end
            end
        end
    end

    // watchdog on cycles without any accepted request or result
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles > STALL_MAX) begin
                $display("timeout: no progress for %0d cycles", STALL_MAX);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // extremes, identity, permutation, triangular, mixed, singular and saturating cases
    task automatic test_directed();
        t_mat m;
        send_matrix(diag_matrix(ONE, ONE, ONE));
        send_matrix('0);
        send_matrix(diag_matrix(32'h0002_0000, 32'hfffe_0000, 32'h0000_8000));
        send_matrix(diag_matrix(32'h1, 32'h1, 32'h1));
        send_matrix(diag_matrix(32'hffff_ffff, 32'h1, 32'hffff_ffff));
        send_matrix(diag_matrix(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
        send_matrix(diag_matrix(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_matrix(diag_matrix(32'h8000_0000, 32'h7fff_ffff, 32'h1));
        for (int i = 0; i < NUM_ENTRIES; i++) m[i] = 32'h7fff_ffff;
        send_matrix(m);
        for (int i = 0; i < NUM_ENTRIES; i++) m[i] = 32'h8000_0000;
        send_matrix(m);
        for (int i = 0; i < NUM_ENTRIES; i++) m[i] = (i % 2) ? 32'h8000_0000 : 32'h7fff_ffff;
        send_matrix(m);
        // permutation matrix
        m = '0;
        m[1] = ONE;
        m[5] = ONE;
        m[6] = ONE;
        send_matrix(m);
        // upper triangular with fractional pivots
        m = diag_matrix(32'h0000_c000, 32'h0003_0000, 32'hffff_4000);
        m[1] = 32'h0001_8000;
        m[2] = 32'hfff0_0000;
        m[5] = 32'h0000_0003;
        send_matrix(m);
        // full-magnitude well-mixed matrix
        m = {32'h1234_5678, 32'hedcb_a987, 32'h0f0f_0f0f, 32'hf0f0_f0f0, 32'h5555_5555,
             32'haaaa_aaaa, 32'h0000_ffff, 32'hffff_0000, 32'h3c3c_3c3c};
        send_matrix(m);
        // two equal rows
        m = {32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'h0005_0000,
             32'h0006_0000, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000};
        send_matrix(m);
        drop_valid();
        wait_drained();
    endtask

    task automatic test_random(int count, int s_idle, int r_idle);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        for (int k = 0; k < count; k++) send_matrix(rand_matrix());
        drop_valid();
    endtask

    // long receiver hold-off while requests keep coming
    task automatic test_backpressure();
        send_idle_pct    = 0;
        recv_idle_pct    = 0;
        @(negedge i_clk);
        recv_hold_cycles = 300;
        for (int k = 0; k < 120; k++) send_matrix(rand_matrix());
        drop_valid();
    endtask

    // pause the sender until the pipeline is empty, then resume
    task automatic test_drain_pause();
        wait_drained();
        repeat (5) send_matrix(rand_matrix());
        drop_valid();
        wait_drained();
    endtask

    initial begin
        n_fail           = 0;
        n_sent           = 0;
        n_checked        = 0;
        n_singular_seen  = 0;
        n_sat_seen       = 0;
        send_idle_pct    = 0;
        recv_idle_pct    = 0;
        recv_hold_cycles = 0;
        quiet_cycles     = 0;
        i_valid          = 1'b0;
        i_ready          = 1'b0;
        for (int i = 0; i < NUM_ENTRIES; i++) i_m[i] = '0;
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random(400, 15, 84);
        test_drain_pause();
        test_random(400, 84, 15);
        test_backpressure();
        test_drain_pause();
        test_random(400, 0, 0);

        wait_drained();
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("%0d matrices sent, %0d inverses checked (%0d singular, %0d saturated entries)",
                 n_sent, n_checked, n_singular_seen, n_sat_seen);
        $display("stalls on both sides, long output hold-off and drain pauses exercised");
        if (n_fail == 0 && inv_expected_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
